>>> hw/rtl/irt_pkg.sv
package irt_pkg;

  // width of the integer taken on the input stream
  localparam int unsigned VALUE_BITS = 32;

  // input tdata is the value filled up to whole bytes
  localparam int unsigned IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

  // character store: one entry per digit plus the sign
  localparam int unsigned STORE_DEPTH = VALUE_BITS + 1;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  // radix register
  localparam int unsigned RADIX_W = 6;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // divider: quotient bits resolved per cycle and the number of iterations per digit
  localparam int unsigned DIV_STEP     = 8;
  localparam int unsigned DIV_CYCLES   = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIV_PAD_BITS = DIV_CYCLES * DIV_STEP;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_CYCLES + 1);

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [RADIX_W-1:0] DIGIT_TEN = RADIX_W'(10);

  // digit value to its ascii character
  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + 8'(d);
    end else begin
      c = CHAR_A + 8'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/irt_ram.sv
module irt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/irt_divider.sv
module irt_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [irt_pkg::VALUE_BITS-1:0]       dividend_i,
  input  logic [irt_pkg::RADIX_W-1:0]          radix_i,
  output logic                                 done_o,
  output logic [irt_pkg::VALUE_BITS-1:0]       quotient_o,
  output logic [irt_pkg::RADIX_W-1:0]          remainder_o
);

  logic                                 busy_q;
  logic                                 done_q;
  logic [irt_pkg::DIV_CNT_W-1:0]        cnt_q;
  logic [irt_pkg::DIV_PAD_BITS-1:0]     quo_q, quo_d;
  logic [irt_pkg::RADIX_W-1:0]          rem_q, rem_d;

  // restoring division, DIV_STEP quotient bits per cycle on a narrow remainder
  always_comb begin
    logic [irt_pkg::RADIX_W:0]        r;
    logic [irt_pkg::DIV_PAD_BITS-1:0] q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int i = 0; i < int'(irt_pkg::DIV_STEP); i++) begin
      r = {r[irt_pkg::RADIX_W-1:0], q[irt_pkg::DIV_PAD_BITS-1]};
      q = {q[irt_pkg::DIV_PAD_BITS-2:0], 1'b0};
      if (r >= {1'b0, radix_i}) begin
        r    = r - {1'b0, radix_i};
        q[0] = 1'b1;
      end
    end
    rem_d = r[irt_pkg::RADIX_W-1:0];
    quo_d = q;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= irt_pkg::DIV_CNT_W'(irt_pkg::DIV_CYCLES);
      quo_q  <= irt_pkg::DIV_PAD_BITS'(dividend_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - irt_pkg::DIV_CNT_W'(1);
      if (cnt_q == irt_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[irt_pkg::VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

>>> hw/rtl/int_to_radix_text_unit.sv
// Converts one signed 32-bit integer per input transaction into its ASCII text
// in the base held in the radix register (2 to 36, reset 10), most significant
// character first, with a leading '-' for negative values and tlast on the
// final character. Digits come from a shared iterative divider that resolves
// 8 quotient bits per cycle; the characters go into a small store and are then
// read back one per cycle while the output is not stalled. The input is not
// ready until the last character has been loaded into the output register.
// Radix writes outside 2 to 36 are ignored.
module int_to_radix_text_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write: radix
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [irt_pkg::RADIX_W-1:0]         cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [irt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [31:0] value
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] char_out
  output logic                                m_axis_tlast
);

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StSign,
    StEmitStart,
    StEmit
  } state_e;

  state_e                             state_q;
  logic [irt_pkg::RADIX_W-1:0]        radix_q;
  logic                               neg_q;
  logic [irt_pkg::CNT_W-1:0]          count_q;
  logic [irt_pkg::CNT_W-1:0]          count_m1;
  logic [irt_pkg::ADDR_W-1:0]         idx_q;
  logic                               out_valid_q;
  logic [7:0]                         out_data_q;
  logic                               out_last_q;

  logic                               in_fire;
  logic                               out_free;
  logic                               emit;
  logic [irt_pkg::VALUE_BITS-1:0]     in_value;
  logic                               in_neg;
  logic [irt_pkg::VALUE_BITS-1:0]     in_mag;

  logic                               div_start;
  logic [irt_pkg::VALUE_BITS-1:0]     div_dividend;
  logic                               div_done;
  logic [irt_pkg::VALUE_BITS-1:0]     div_quotient;
  logic [irt_pkg::RADIX_W-1:0]        div_remainder;
  logic                               quo_zero;

  logic                               ram_we;
  logic [irt_pkg::ADDR_W-1:0]         ram_waddr;
  logic [7:0]                         ram_wdata;
  logic                               ram_re;
  logic [irt_pkg::ADDR_W-1:0]         ram_raddr;
  logic [7:0]                         ram_rdata;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = (state_q == StEmit) && out_free;

  // magnitude of the incoming value, the most negative value wraps to itself
  assign in_value = s_axis_tdata[irt_pkg::VALUE_BITS-1:0];
  assign in_neg   = in_value[irt_pkg::VALUE_BITS-1];
  assign in_mag   = in_neg ? (~in_value + irt_pkg::VALUE_BITS'(1)) : in_value;

  // divider feed: first digit from the input, then from the last quotient
  assign quo_zero     = (div_quotient == '0);
  assign div_start    = in_fire || ((state_q == StDivide) && div_done && !quo_zero);
  assign div_dividend = (state_q == StIdle) ? in_mag : div_quotient;

  irt_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .radix_i     (radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  // character store access
  assign count_m1  = count_q - irt_pkg::CNT_W'(1);
  assign ram_we    = ((state_q == StDivide) && div_done) || (state_q == StSign);
  assign ram_waddr = count_q[irt_pkg::ADDR_W-1:0];
  assign ram_wdata = (state_q == StSign) ? irt_pkg::CHAR_MINUS
                                         : irt_pkg::digit_char(div_remainder);
  assign ram_re    = (state_q == StEmitStart)
                  || ((state_q == StEmit) && out_free && (idx_q != '0));
  assign ram_raddr = (state_q == StEmitStart) ? count_m1[irt_pkg::ADDR_W-1:0]
                                              : idx_q - irt_pkg::ADDR_W'(1);

  irt_ram #(
    .WIDTH (8),
    .DEPTH (irt_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer, radix register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      radix_q     <= irt_pkg::RADIX_RESET;
      neg_q       <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o
          && (cfg_data_i >= irt_pkg::RADIX_MIN) && (cfg_data_i <= irt_pkg::RADIX_MAX)) begin
        radix_q <= cfg_data_i;
      end

      // output valid: set on a new character, cleared once taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            neg_q   <= in_neg;
            count_q <= '0;
            state_q <= StDivide;
          end
        end
        StDivide: begin
          if (div_done) begin
            count_q <= count_q + irt_pkg::CNT_W'(1);
            if (quo_zero) begin
              state_q <= neg_q ? StSign : StEmitStart;
            end
          end
        end
        StSign: begin
          count_q <= count_q + irt_pkg::CNT_W'(1);
          state_q <= StEmitStart;
        end
        StEmitStart: begin
          idx_q   <= count_m1[irt_pkg::ADDR_W-1:0];
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_data_q  <= ram_rdata;
            out_last_q  <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q - irt_pkg::ADDR_W'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> test/tb_int_to_radix_text_unit.sv
module tb_int_to_radix_text_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // one value waiting to be sent, optionally after the block has drained
  typedef struct {
    logic [irt_pkg::VALUE_BITS-1:0] value;
    bit                             drain_first;
  } value_item_t;

  // one expected character of the output text
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [irt_pkg::RADIX_W-1:0]    cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [irt_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // [7:0] char_out
  logic                           m_axis_tlast;

  value_item_t                 pending_values[$];
  text_char_t                  text_expected[$];
  logic [irt_pkg::RADIX_W-1:0] radix_setting = irt_pkg::RADIX_RESET;

  bit          value_busy = 1'b0;
  bit          value_taken = 1'b0;
  bit          char_taken = 1'b0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned value_gap = 0;
  int unsigned char_wait = 0;
  int unsigned fail_count = 0;
  int unsigned values_done = 0;
  int unsigned chars_checked = 0;
  int unsigned radix_writes = 0;

  int_to_radix_text_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected text of one value in the current radix, most significant first
  function automatic void push_radix_text(input logic [irt_pkg::VALUE_BITS-1:0] v);
    logic [irt_pkg::VALUE_BITS-1:0] mag;
    logic [irt_pkg::RADIX_W-1:0]    d;
    logic [7:0]                     chars[$];
    text_char_t                     tc;
    bit                             neg;
    neg = v[irt_pkg::VALUE_BITS-1];
    mag = neg ? -v : v;
    do begin
      d = irt_pkg::RADIX_W'(mag % irt_pkg::VALUE_BITS'(radix_setting));
      if (d < irt_pkg::DIGIT_TEN) begin
        chars.push_front(irt_pkg::CHAR_ZERO + 8'(d));
      end else begin
        chars.push_front(irt_pkg::CHAR_A + 8'(d - irt_pkg::DIGIT_TEN));
      end
      mag = mag / irt_pkg::VALUE_BITS'(radix_setting);
    end while (mag != '0);
    if (neg) begin
      chars.push_front(irt_pkg::CHAR_MINUS);
    end
    foreach (chars[i]) begin
      tc.ch   = chars[i];
      tc.last = (i == chars.size() - 1);
      text_expected.push_back(tc);
    end
  endfunction

  // random value: wide, small, extremes, or near a power of the radix
  function automatic logic [irt_pkg::VALUE_BITS-1:0] random_value();
    logic [irt_pkg::VALUE_BITS-1:0] p;
    logic [irt_pkg::VALUE_BITS-1:0] p_limit;
    p       = irt_pkg::VALUE_BITS'(1);
    p_limit = {1'b0, {(irt_pkg::VALUE_BITS-1){1'b1}}}
              / irt_pkg::VALUE_BITS'(radix_setting);
    case ($urandom_range(0, 5))
      1: return irt_pkg::VALUE_BITS'($urandom_range(0, 1500));
      2: return -irt_pkg::VALUE_BITS'($urandom_range(0, 1500));
      3: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(irt_pkg::VALUE_BITS-1){1'b0}}};
          1: return {1'b0, {(irt_pkg::VALUE_BITS-1){1'b1}}};
          2: return '1;
          default: return '0;
        endcase
      end
      4: begin
        repeat ($urandom_range(1, 31)) begin
          if (p < p_limit) begin
            p = p * irt_pkg::VALUE_BITS'(radix_setting);
          end
        end
        p = p + irt_pkg::VALUE_BITS'($urandom_range(0, 2)) - irt_pkg::VALUE_BITS'(1);
        return $urandom_range(0, 1) ? -p : p;
      end
      default: return irt_pkg::VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_value(input logic [irt_pkg::VALUE_BITS-1:0] v, input bit drain);
    value_item_t item;
    item.value       = v;
    item.drain_first = drain;
    pending_values.push_back(item);
  endtask

  // wait until every queued value is sent and its text has come back
  task automatic wait_idle();
    while (pending_values.size() != 0 || value_busy || text_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // one transaction on the radix write channel, block idle
  task automatic write_radix(input logic [irt_pkg::RADIX_W-1:0] r);
    @(negedge clk_i);
    cfg_data_i  <= r;
    cfg_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (r >= irt_pkg::RADIX_MIN && r <= irt_pkg::RADIX_MAX) begin
      radix_setting = r;
    end
    radix_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // input driver: optional gap after each value, valid held until the transaction
  always @(negedge clk_i) begin : value_driver
    value_item_t item;
    if (rst_ni) begin
      if (value_taken) begin
        value_taken = 1'b0;
        value_busy  = 1'b0;
      end
      if (!value_busy) begin
        if (value_gap != 0) begin
          value_gap--;
        end else if (pending_values.size() != 0 &&
                     !(pending_values[0].drain_first && text_expected.size() != 0)) begin
          item = pending_values.pop_front();
          s_axis_tdata <= irt_pkg::IN_TDATA_W'(item.value);
          value_busy = 1'b1;
          value_gap  = send_idle ? $urandom_range(0, 12) : 0;
        end
      end
      s_axis_tvalid <= value_busy;
    end
  end

  // output sink: optional stall after each character
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (char_taken) begin
        char_taken = 1'b0;
        char_wait  = recv_idle ? $urandom_range(0, 12) : 0;
      end
      if (char_wait != 0) begin
        char_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // check characters, then predict text for each accepted value
  always @(posedge clk_i) begin : text_monitor
    text_char_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        char_taken = 1'b1;
        if (text_expected.size() == 0) begin
          $error("char_out: no character expected, got 0x%02h last %0b",
                 m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = text_expected.pop_front();
          chars_checked++;
          if (m_axis_tdata !== want.ch) begin
            $error("char_out: expected 0x%02h, got 0x%02h", want.ch, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        value_taken = 1'b1;
        values_done++;
        push_radix_text(s_axis_tdata[irt_pkg::VALUE_BITS-1:0]);
      end
    end
  end

  // run limit
  initial begin
    #10ms;
    $display("int_to_radix_text_unit verification failed");
    $finish;
  end

  initial begin
    logic [irt_pkg::RADIX_W-1:0] radix_plan[10];
    radix_plan = '{irt_pkg::RADIX_W'(2), irt_pkg::RADIX_W'(36), irt_pkg::RADIX_W'(10),
                   irt_pkg::RADIX_W'(16), irt_pkg::RADIX_W'(8), irt_pkg::RADIX_W'(3),
                   irt_pkg::RADIX_W'(35), irt_pkg::RADIX_W'(7), irt_pkg::RADIX_W'(2),
                   irt_pkg::RADIX_W'(36)};
    radix_plan[8] = irt_pkg::RADIX_W'($urandom_range(2, 36));
    radix_plan[9] = irt_pkg::RADIX_W'($urandom_range(2, 36));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset radix: zero, signs, extremes
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(-32'sd1, 1'b0);
    queue_value(32'd9, 1'b0);
    queue_value(32'd10, 1'b0);
    queue_value(-32'sd10, 1'b0);
    queue_value(32'h7FFF_FFFF, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'd123456789, 1'b0);
    queue_value(-32'sd987654321, 1'b0);
    wait_idle();

    // binary: longest texts, most negative value needs 33 characters
    write_radix(irt_pkg::RADIX_W'(2));
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(-32'sd1, 1'b0);
    queue_value(32'h7FFF_FFFF, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'h5555_5555, 1'b0);
    queue_value(32'hAAAA_AAAA, 1'b0);
    wait_idle();

    // out of range writes are dropped, then base 36 with letter digits
    write_radix(irt_pkg::RADIX_W'(63));
    write_radix(irt_pkg::RADIX_W'(0));
    write_radix(irt_pkg::RADIX_W'(36));
    queue_value(32'd0, 1'b0);
    queue_value(32'd35, 1'b0);
    queue_value(32'd36, 1'b0);
    queue_value(-32'sd35, 1'b0);
    queue_value(32'h7FFF_FFFF, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'd1295, 1'b0);
    wait_idle();

    // random phases over several radix settings
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 2) write_radix(irt_pkg::RADIX_W'(37));
      if (ph == 5) write_radix(irt_pkg::RADIX_W'(1));
      write_radix(radix_plan[ph]);
      send_idle = (ph % 3 != 0) ? 1'($urandom_range(0, 1)) : 1'b0;
      recv_idle = (ph % 3 != 0) ? 1'b1 : 1'b0;
      if (ph % 3 == 2) send_idle = 1'b1;
      for (int i = 0; i < 24; i++) begin
        queue_value(random_value(), (i == 13) || ($urandom_range(0, 29) == 0));
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("converted %0d values into %0d checked characters", values_done, chars_checked);
    $display("radix register written %0d times, out of range writes included",
             radix_writes);
    if (fail_count == 0) begin
      $display("int_to_radix_text_unit verification clean");
    end else begin
      $display("int_to_radix_text_unit verification failed");
    end
    $finish;
  end

endmodule
